// File: sv/assert_macros.svh
// Assertion macros used by the checker file of the collision core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ECOL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("collision core: property violated");

// Next-cycle implication, disabled while reset is asserted.
`define ECOL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("collision core: property violated");

`endif

// File: sv/ecol_pkg.sv
// Package with the shared constants of the elastic collision core.
package ecol_pkg;

  // Default width of every velocity, mass and separation word.
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // Bits of the second operand consumed by one multiplier stage.
  localparam int unsigned MUL_DIGIT = 16;

endpackage

// File: sv/ecol_mul.sv
// Pipelined multi-lane unsigned multiplier that takes one digit of the multiplier per stage.
module ecol_mul #(
  parameter int unsigned AW    = 33,
  parameter int unsigned BW    = 32,
  parameter int unsigned LANES = 1,
  parameter int unsigned SW    = 1,
  parameter int unsigned DIG   = ecol_pkg::MUL_DIGIT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [AW-1:0]        a_i [LANES],
  input  logic [BW-1:0]        b_i [LANES],
  input  logic [SW-1:0]        side_i,
  output logic                 valid_o,
  output logic [AW+BW-1:0]     p_o [LANES],
  output logic [SW-1:0]        side_o
);

  localparam int unsigned NST = (BW + DIG - 1) / DIG;
  localparam int unsigned PW  = AW + BW;
  localparam int unsigned BPW = NST * DIG;

  logic [PW-1:0]  acc_q  [NST][LANES];
  logic [AW-1:0]  a_q    [NST][LANES];
  logic [BPW-1:0] b_q    [NST][LANES];
  logic [SW-1:0]  side_q [NST];
  logic           vld_q  [NST];

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic [PW-1:0]     acc_in [LANES];
    logic [PW-1:0]     acc_d  [LANES];
    logic [AW-1:0]     a_in   [LANES];
    logic [BPW-1:0]    b_in   [LANES];
    logic [AW+DIG-1:0] pp     [LANES];
    logic [SW-1:0]     side_in;
    logic              vld_in;

    // Select the operands of this stage: the ports or the previous stage.
    if (k == 0) begin : g_first
      always_comb begin
        vld_in  = valid_i;
        side_in = side_i;
        for (int l = 0; l < LANES; l++) begin
          acc_in[l] = '0;
          a_in[l]   = a_i[l];
          b_in[l]   = BPW'(b_i[l]);
        end
      end
    end else begin : g_next
      always_comb begin
        vld_in  = vld_q[k-1];
        side_in = side_q[k-1];
        for (int l = 0; l < LANES; l++) begin
          acc_in[l] = acc_q[k-1][l];
          a_in[l]   = a_q[k-1][l];
          b_in[l]   = b_q[k-1][l];
        end
      end
    end

    // Add one partial product at the weight of this stage's digit.
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        pp[l]    = a_in[l] * b_in[l][DIG-1:0];
        acc_d[l] = acc_in[l] + (PW'(pp[l]) << (k * DIG));
      end
    end

    // The valid bit of the stage is control state and is reset.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    // Stage payload.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
        for (int l = 0; l < LANES; l++) begin
          acc_q[k][l] <= acc_d[l];
          a_q[k][l]   <= a_in[l];
          b_q[k][l]   <= b_in[l] >> DIG;
        end
      end
    end
  end

  assign valid_o = vld_q[NST-1];
  assign p_o     = acc_q[NST-1];
  assign side_o  = side_q[NST-1];

endmodule

// File: sv/ecol_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a final round-half-up stage.
module ecol_div #(
  parameter int unsigned NW    = 130,
  parameter int unsigned DENW  = 98,
  parameter int unsigned QW    = 33,
  parameter int unsigned LANES = 1,
  parameter int unsigned SW    = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NW-1:0]     num_i [LANES],
  input  logic [DENW-1:0]   den_i,
  input  logic [SW-1:0]     side_i,
  output logic              valid_o,
  output logic [QW:0]       quot_o [LANES],
  output logic [SW-1:0]     side_o
);

  logic [NW-1:0]   rem_q  [QW][LANES];
  logic [QW-1:0]   q_q    [QW][LANES];
  logic [DENW-1:0] den_q  [QW];
  logic [SW-1:0]   side_q [QW];
  logic            vld_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int unsigned BIT = QW - 1 - k;

    logic [NW-1:0]   rem_in [LANES];
    logic [NW-1:0]   rem_d  [LANES];
    logic [QW-1:0]   q_in   [LANES];
    logic [QW-1:0]   q_d    [LANES];
    logic [DENW-1:0] den_in;
    logic [NW:0]     dsh;
    logic [SW-1:0]   side_in;
    logic            vld_in;

    // Select the partial remainder: the dividend or the previous stage.
    if (k == 0) begin : g_first
      always_comb begin
        vld_in  = valid_i;
        side_in = side_i;
        den_in  = den_i;
        for (int l = 0; l < LANES; l++) begin
          rem_in[l] = num_i[l];
          q_in[l]   = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        vld_in  = vld_q[k-1];
        side_in = side_q[k-1];
        den_in  = den_q[k-1];
        for (int l = 0; l < LANES; l++) begin
          rem_in[l] = rem_q[k-1][l];
          q_in[l]   = q_q[k-1][l];
        end
      end
    end

    // Subtract the shifted divisor where it fits and set this quotient bit.
    always_comb begin
      dsh = (NW + 1)'(den_in) << BIT;
      for (int l = 0; l < LANES; l++) begin
        rem_d[l] = rem_in[l];
        q_d[l]   = q_in[l];
        if ({1'b0, rem_in[l]} >= dsh) begin
          rem_d[l] = rem_in[l] - dsh[NW-1:0];
          q_d[l]   = q_in[l] | (QW'(1) << BIT);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
        for (int l = 0; l < LANES; l++) begin
          rem_q[k][l] <= rem_d[l];
          q_q[k][l]   <= q_d[l];
        end
      end
    end
  end

  // Round half up: bump the quotient when twice the remainder reaches the divisor.
  logic [QW:0]   quot_d [LANES];
  logic [QW:0]   quot_q [LANES];
  logic [SW-1:0] side_fq;
  logic          vld_fq;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quot_d[l] = (QW + 1)'(q_q[QW-1][l]);
      if ({rem_q[QW-1][l], 1'b0} >= (NW + 1)'(den_q[QW-1])) begin
        quot_d[l] = quot_d[l] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_fq <= 1'b0;
    end else if (en_i) begin
      vld_fq <= vld_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_fq <= side_q[QW-1];
      quot_q  <= quot_d;
    end
  end

  assign valid_o = vld_fq;
  assign quot_o  = quot_q;
  assign side_o  = side_fq;

endmodule

// File: sv/elastic_collision_2d_core.sv
// Throughput: one word per cycle; a stall on the output freezes the whole pipeline.
// The depth is set by the restoring divider, which resolves one quotient bit per stage.
// Reset is asynchronous and active low; it clears the valid bits of every stage.
// Payload registers are not reset.
module elastic_collision_2d_core #(
  parameter int unsigned VALUE_WIDTH = ecol_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [VALUE_WIDTH-1:0] vel_a_x_i,
  input  logic signed [VALUE_WIDTH-1:0] vel_a_y_i,
  input  logic        [VALUE_WIDTH-1:0] mass_a_i,
  input  logic signed [VALUE_WIDTH-1:0] vel_b_x_i,
  input  logic signed [VALUE_WIDTH-1:0] vel_b_y_i,
  input  logic        [VALUE_WIDTH-1:0] mass_b_i,
  input  logic signed [VALUE_WIDTH-1:0] sep_x_i,
  input  logic signed [VALUE_WIDTH-1:0] sep_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [VALUE_WIDTH-1:0] new_a_x_o,
  output logic signed [VALUE_WIDTH-1:0] new_a_y_o,
  output logic signed [VALUE_WIDTH-1:0] new_b_x_o,
  output logic signed [VALUE_WIDTH-1:0] new_b_y_o,
  output logic                          degenerate_o,
  output logic                          saturated_o
);

  localparam int unsigned W   = VALUE_WIDTH;
  localparam int unsigned DW  = 2 * W + 1;  // d.d and |(vb - va).d|
  localparam int unsigned PW3 = 3 * W + 2;  // denominator and 2m*diff
  localparam int unsigned NW  = 4 * W + 2;  // full numerator
  localparam int unsigned QW  = W + 1;      // quotient bits before rounding

  localparam logic [W+2:0] RMAX = {4'b0000, {(W - 1){1'b1}}};
  localparam logic [W+2:0] RMIN = {4'b1111, {(W - 1){1'b0}}};

  typedef struct packed {
    logic [W-1:0] vax, vay, vbx, vby;
    logic [W-1:0] ma, mb;
    logic [W-1:0] adx, ady;
    logic         sdx, sdy, sx, sy, degen;
  } side1_t;

  typedef struct packed {
    logic [W-1:0] vax, vay, vbx, vby;
    logic [W-1:0] adx, ady;
    logic         sdx, sdy, dsign, degen;
  } side2_t;

  typedef struct packed {
    logic [W-1:0]   vax, vay, vbx, vby;
    logic           nax, nay, degen;
    logic [PW3-1:0] den;
  } side3_t;

  typedef struct packed {
    logic [W-1:0] vax, vay, vbx, vby;
    logic         nax, nay, degen;
  } side4_t;

  // Global advance: every stage moves unless a finished word is held.
  logic adv;
  logic out_valid_q;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // Input register.
  logic         s0_vld_q;
  logic [W-1:0] s0_vax_q, s0_vay_q, s0_vbx_q, s0_vby_q;
  logic [W-1:0] s0_ma_q, s0_mb_q, s0_dx_q, s0_dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (adv) begin
      s0_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_vax_q <= vel_a_x_i;
      s0_vay_q <= vel_a_y_i;
      s0_vbx_q <= vel_b_x_i;
      s0_vby_q <= vel_b_y_i;
      s0_ma_q  <= mass_a_i;
      s0_mb_q  <= mass_b_i;
      s0_dx_q  <= sep_x_i;
      s0_dy_q  <= sep_y_i;
    end
  end

  // Signs and magnitudes of the separation and of the velocity difference.
  logic [W:0]   dvx, dvy, advx, advy;
  logic [W-1:0] adx, ady;
  logic         sdx, sdy;
  side1_t       side1_in;

  always_comb begin
    sdx  = s0_dx_q[W-1];
    sdy  = s0_dy_q[W-1];
    adx  = sdx ? (~s0_dx_q + 1'b1) : s0_dx_q;
    ady  = sdy ? (~s0_dy_q + 1'b1) : s0_dy_q;
    dvx  = {s0_vbx_q[W-1], s0_vbx_q} - {s0_vax_q[W-1], s0_vax_q};
    dvy  = {s0_vby_q[W-1], s0_vby_q} - {s0_vay_q[W-1], s0_vay_q};
    advx = dvx[W] ? (~dvx + 1'b1) : dvx;
    advy = dvy[W] ? (~dvy + 1'b1) : dvy;

    side1_in.vax   = s0_vax_q;
    side1_in.vay   = s0_vay_q;
    side1_in.vbx   = s0_vbx_q;
    side1_in.vby   = s0_vby_q;
    side1_in.ma    = s0_ma_q;
    side1_in.mb    = s0_mb_q;
    side1_in.adx   = adx;
    side1_in.ady   = ady;
    side1_in.sdx   = sdx;
    side1_in.sdy   = sdy;
    side1_in.sx    = dvx[W] ^ sdx;
    side1_in.sy    = dvy[W] ^ sdy;
    side1_in.degen = ((s0_dx_q == '0) && (s0_dy_q == '0)) ||
                     ((s0_ma_q == '0) && (s0_mb_q == '0));
  end

  // First products: dx*dx, dy*dy, dvx*dx, dvy*dy on magnitudes.
  logic [W:0]    m1_a [4];
  logic [W-1:0]  m1_b [4];
  logic [DW-1:0] m1_p [4];
  logic          m1_vld;
  side1_t        side1_out;

  assign m1_a[0] = {1'b0, adx};
  assign m1_b[0] = adx;
  assign m1_a[1] = {1'b0, ady};
  assign m1_b[1] = ady;
  assign m1_a[2] = advx;
  assign m1_b[2] = adx;
  assign m1_a[3] = advy;
  assign m1_b[3] = ady;

  ecol_mul #(
    .AW(W + 1), .BW(W), .LANES(4), .SW($bits(side1_t))
  ) u_mul_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s0_vld_q),
    .a_i     (m1_a),
    .b_i     (m1_b),
    .side_i  (side1_in),
    .valid_o (m1_vld),
    .p_o     (m1_p),
    .side_o  (side1_out)
  );

  // Sum stage: d.d, the signed projection (vb - va).d and the mass terms.
  logic signed [DW+1:0] tx, ty, dsum;
  logic [DW-1:0]        dd_d, dmag_d;
  logic                 s2_vld_q;
  logic [DW-1:0]        s2_dd_q, s2_dmag_q;
  logic [W:0]           s2_msum_q, s2_m2a_q, s2_m2b_q;
  side2_t               s2_side_q, side2_d;

  always_comb begin
    dd_d   = DW'(m1_p[0] + m1_p[1]);
    tx     = side1_out.sx ? -$signed({2'b00, m1_p[2]}) : $signed({2'b00, m1_p[2]});
    ty     = side1_out.sy ? -$signed({2'b00, m1_p[3]}) : $signed({2'b00, m1_p[3]});
    dsum   = tx + ty;
    dmag_d = dsum[DW+1] ? DW'(-dsum) : DW'(dsum);

    side2_d.vax   = side1_out.vax;
    side2_d.vay   = side1_out.vay;
    side2_d.vbx   = side1_out.vbx;
    side2_d.vby   = side1_out.vby;
    side2_d.adx   = side1_out.adx;
    side2_d.ady   = side1_out.ady;
    side2_d.sdx   = side1_out.sdx;
    side2_d.sdy   = side1_out.sdy;
    side2_d.dsign = dsum[DW+1];
    side2_d.degen = side1_out.degen;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= m1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_dd_q   <= dd_d;
      s2_dmag_q <= dmag_d;
      s2_msum_q <= {1'b0, side1_out.ma} + {1'b0, side1_out.mb};
      s2_m2a_q  <= {side1_out.ma, 1'b0};
      s2_m2b_q  <= {side1_out.mb, 1'b0};
      s2_side_q <= side2_d;
    end
  end

  // Second products: the denominator and the two mass-weighted projections.
  logic [DW-1:0]  m2_a [3];
  logic [W:0]     m2_b [3];
  logic [PW3-1:0] m2_p [3];
  logic           m2_vld;
  side2_t         side2_out;

  assign m2_a[0] = s2_dd_q;
  assign m2_b[0] = s2_msum_q;
  assign m2_a[1] = s2_dmag_q;
  assign m2_b[1] = s2_m2b_q;
  assign m2_a[2] = s2_dmag_q;
  assign m2_b[2] = s2_m2a_q;

  ecol_mul #(
    .AW(DW), .BW(W + 1), .LANES(3), .SW($bits(side2_t))
  ) u_mul_mass (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s2_vld_q),
    .a_i     (m2_a),
    .b_i     (m2_b),
    .side_i  (s2_side_q),
    .valid_o (m2_vld),
    .p_o     (m2_p),
    .side_o  (side2_out)
  );

  // Third products: scale each weighted projection by a separation component.
  logic [PW3-1:0] m3_a [4];
  logic [W-1:0]   m3_b [4];
  logic [NW-1:0]  m3_p [4];
  logic           m3_vld;
  side3_t         side3_in, side3_out;

  always_comb begin
    m3_a[0] = m2_p[1];
    m3_b[0] = side2_out.adx;
    m3_a[1] = m2_p[1];
    m3_b[1] = side2_out.ady;
    m3_a[2] = m2_p[2];
    m3_b[2] = side2_out.adx;
    m3_a[3] = m2_p[2];
    m3_b[3] = side2_out.ady;

    side3_in.vax   = side2_out.vax;
    side3_in.vay   = side2_out.vay;
    side3_in.vbx   = side2_out.vbx;
    side3_in.vby   = side2_out.vby;
    side3_in.nax   = side2_out.sdx ^ side2_out.dsign;
    side3_in.nay   = side2_out.sdy ^ side2_out.dsign;
    side3_in.degen = side2_out.degen;
    side3_in.den   = m2_p[0];
  end

  ecol_mul #(
    .AW(PW3), .BW(W), .LANES(4), .SW($bits(side3_t))
  ) u_mul_sep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (m2_vld),
    .a_i     (m3_a),
    .b_i     (m3_b),
    .side_i  (side3_in),
    .valid_o (m3_vld),
    .p_o     (m3_p),
    .side_o  (side3_out)
  );

  // Division of the four numerators by the shared denominator.
  side4_t      side4_in, side4_out;
  logic [QW:0] quot [4];
  logic        div_vld;

  always_comb begin
    side4_in.vax   = side3_out.vax;
    side4_in.vay   = side3_out.vay;
    side4_in.vbx   = side3_out.vbx;
    side4_in.vby   = side3_out.vby;
    side4_in.nax   = side3_out.nax;
    side4_in.nay   = side3_out.nay;
    side4_in.degen = side3_out.degen;
  end

  ecol_div #(
    .NW(NW), .DENW(PW3), .QW(QW), .LANES(4), .SW($bits(side4_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (m3_vld),
    .num_i   (m3_p),
    .den_i   (side3_out.den),
    .side_i  (side4_in),
    .valid_o (div_vld),
    .quot_o  (quot),
    .side_o  (side4_out)
  );

  // Apply the correction to each velocity and clamp to the signed range; a degenerate pair keeps its velocities.
  logic [W-1:0]        vel [4];
  logic                neg [4];
  logic signed [W+2:0] res [4];
  logic [W-1:0]        new_d [4];
  logic                sat_d;

  always_comb begin
    vel[0] = side4_out.vax;
    vel[1] = side4_out.vay;
    vel[2] = side4_out.vbx;
    vel[3] = side4_out.vby;
    neg[0] = side4_out.nax;
    neg[1] = side4_out.nay;
    neg[2] = !side4_out.nax;
    neg[3] = !side4_out.nay;
    sat_d  = 1'b0;
    for (int l = 0; l < 4; l++) begin
      res[l] = neg[l] ? $signed({{3{vel[l][W-1]}}, vel[l]}) - $signed({1'b0, quot[l]})
                      : $signed({{3{vel[l][W-1]}}, vel[l]}) + $signed({1'b0, quot[l]});
      new_d[l] = res[l][W-1:0];
      if (res[l] > $signed(RMAX)) begin
        new_d[l] = RMAX[W-1:0];
        sat_d    = 1'b1;
      end else if (res[l] < $signed(RMIN)) begin
        new_d[l] = RMIN[W-1:0];
        sat_d    = 1'b1;
      end
    end
    if (side4_out.degen) begin
      new_d = vel;
      sat_d = 1'b0;
    end
  end

  // Output register.
  logic [W-1:0] new_q [4];
  logic         degen_q, sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      new_q   <= new_d;
      degen_q <= side4_out.degen;
      sat_q   <= sat_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign new_a_x_o    = new_q[0];
  assign new_a_y_o    = new_q[1];
  assign new_b_x_o    = new_q[2];
  assign new_b_y_o    = new_q[3];
  assign degenerate_o = degen_q;
  assign saturated_o  = sat_q;

endmodule

// File: sv/ecol_checker.sv
// Port-level checker for the collision core and its bind statement.
`include "assert_macros.svh"

module ecol_checker #(
  parameter int unsigned VALUE_WIDTH = ecol_pkg::VALUE_WIDTH_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [VALUE_WIDTH-1:0] new_a_x_o,
  input logic [VALUE_WIDTH-1:0] new_a_y_o,
  input logic [VALUE_WIDTH-1:0] new_b_x_o,
  input logic [VALUE_WIDTH-1:0] new_b_y_o,
  input logic                   degenerate_o,
  input logic                   saturated_o
);

  localparam logic [VALUE_WIDTH-1:0] MAXV = {1'b0, {(VALUE_WIDTH - 1){1'b1}}};
  localparam logic [VALUE_WIDTH-1:0] MINV = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};

  // Some velocity component sits at an end of the signed range.
  logic at_lim;

  assign at_lim = (new_a_x_o == MAXV) || (new_a_x_o == MINV) ||
                  (new_a_y_o == MAXV) || (new_a_y_o == MINV) ||
                  (new_b_x_o == MAXV) || (new_b_x_o == MINV) ||
                  (new_b_y_o == MAXV) || (new_b_y_o == MINV);

  // The input side is only held back while a finished word waits downstream.
  `ECOL_ASSERT_IMP(a_stall_needs_word, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // A degenerate pair passes its velocities through and never clamps.
  `ECOL_ASSERT_IMP(a_degen_no_sat, clk_i, rst_ni, out_valid_o && degenerate_o, !saturated_o)

  // A clamped word carries at least one component at an end of the range.
  `ECOL_ASSERT_IMP(a_sat_at_limit, clk_i, rst_ni, out_valid_o && saturated_o, at_lim)

  // A stalled result word stays in place.
  `ECOL_ASSERT_NXT(a_out_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(new_a_x_o) && $stable(new_b_y_o) && $stable(saturated_o))

endmodule

bind elastic_collision_2d_core ecol_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_ecol_checker (.*);

// File: tb/tb_elastic_collision_2d_core.sv
// Self-checking testbench for the two-body elastic collision pipeline.
`timescale 1ns / 100ps

module tb_elastic_collision_2d_core;

  localparam int unsigned W = ecol_pkg::VALUE_WIDTH_DEF;
  localparam int unsigned BW = 192;
  localparam int unsigned RAND_WORDS = 1880;
  localparam int unsigned HOLD_AT = 500;
  localparam int unsigned PAUSE_AT = 1200;
  localparam int unsigned QUIET_LO = 1400;
  localparam int unsigned QUIET_HI = 1600;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam logic signed [63:0] VMAX = (64'sd1 <<< (W - 1)) - 64'sd1;
  localparam logic signed [63:0] VMIN = -(64'sd1 <<< (W - 1));
  localparam logic signed [W-1:0] SMAX = VMAX[W-1:0];
  localparam logic signed [W-1:0] SMIN = VMIN[W-1:0];
  localparam logic [W-1:0] UMAX = '1;
  localparam logic signed [W-1:0] ONE = 1 <<< 16;

  typedef struct packed {
    logic signed [W-1:0] vax;
    logic signed [W-1:0] vay;
    logic [W-1:0]        ma;
    logic signed [W-1:0] vbx;
    logic signed [W-1:0] vby;
    logic [W-1:0]        mb;
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
  } pair_t;

  typedef struct packed {
    logic signed [W-1:0] ax;
    logic signed [W-1:0] ay;
    logic signed [W-1:0] bx;
    logic signed [W-1:0] by;
    logic                degen;
    logic                sat;
  } bounce_t;

  typedef struct packed {
    pair_t   pair;
    bit      typed;
    bounce_t want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  pair_t drv = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  bounce_t got;

  elastic_collision_2d_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .vel_a_x_i    (drv.vax),
    .vel_a_y_i    (drv.vay),
    .mass_a_i     (drv.ma),
    .vel_b_x_i    (drv.vbx),
    .vel_b_y_i    (drv.vby),
    .mass_b_i     (drv.mb),
    .sep_x_i      (drv.dx),
    .sep_y_i      (drv.dy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .new_a_x_o    (got.ax),
    .new_a_y_o    (got.ay),
    .new_b_x_o    (got.bx),
    .new_b_y_o    (got.by),
    .degenerate_o (got.degen),
    .saturated_o  (got.sat)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bounce_t pending_q[$];
  row_t    rows_q[$];
  int unsigned fails = 0;
  int unsigned words_sent = 0;
  int unsigned words_back = 0;
  int unsigned n_degen = 0;
  int unsigned n_sat = 0;
  int unsigned idle_cycles = 0;
  bit in_acc = 1'b0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  // Applies one rounded velocity kick and clamps the sum to the word range.
  function automatic logic [W:0] kick(logic signed [W-1:0] v, logic signed [BW-1:0] t,
                                      logic [BW-1:0] den, bit sub);
    logic [BW-1:0] m;
    logic [BW-1:0] q;
    logic [BW-1:0] r;
    logic signed [63:0] acc;
    bit neg;
    bit sat;
    neg = (t < 0) ^ sub;
    m = (t < 0) ? -t : t;
    q = m / den;
    r = m - q * den;
    if ((r << 1) >= den) q = q + 1;
    if (q > (BW'(1) << (W + 1))) q = BW'(1) << (W + 1);
    acc = v;
    acc = neg ? acc - $signed(q[63:0]) : acc + $signed(q[63:0]);
    sat = 1'b0;
    if (acc > VMAX) begin
      acc = VMAX;
      sat = 1'b1;
    end
    if (acc < VMIN) begin
      acc = VMIN;
      sat = 1'b1;
    end
    return {sat, acc[W-1:0]};
  endfunction

  // Exact closed-form collision: rational arithmetic on wide integers.
  function automatic bounce_t collide(pair_t p);
    logic signed [BW-1:0] dxw, dyw, dvx, dvy, dot, dd, maw, mbw, ka, kb;
    logic [BW-1:0] den;
    logic [W:0] k0, k1, k2, k3;
    bounce_t res;
    maw = p.ma;
    mbw = p.mb;
    if ((p.dx == 0 && p.dy == 0) || (maw + mbw) == 0) begin
      res = '{p.vax, p.vay, p.vbx, p.vby, 1'b1, 1'b0};
      return res;
    end
    dxw = p.dx;
    dyw = p.dy;
    dvx = p.vbx;
    dvx = dvx - p.vax;
    dvy = p.vby;
    dvy = dvy - p.vay;
    dot = dvx * dxw + dvy * dyw;
    dd = dxw * dxw + dyw * dyw;
    den = (maw + mbw) * dd;
    ka = 2 * mbw * dot;
    kb = 2 * maw * dot;
    k0 = kick(p.vax, dxw * ka, den, 1'b0);
    k1 = kick(p.vay, dyw * ka, den, 1'b0);
    k2 = kick(p.vbx, dxw * kb, den, 1'b1);
    k3 = kick(p.vby, dyw * kb, den, 1'b1);
    res = '{k0[W-1:0], k1[W-1:0], k2[W-1:0], k3[W-1:0], 1'b0,
            k0[W] | k1[W] | k2[W] | k3[W]};
    return res;
  endfunction

  function automatic logic signed [W-1:0] rand_vel();
    if ($urandom_range(0, 1)) return $urandom();
    return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
  endfunction

  function automatic logic [W-1:0] rand_mass();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 50) return $urandom_range(1, 1 << 20);
    return $urandom();
  endfunction

  // Random pair: mostly well-formed contacts, with a share of degenerate ones.
  function automatic pair_t rand_pair();
    pair_t p;
    int unsigned r;
    p.vax = rand_vel();
    p.vay = rand_vel();
    p.vbx = rand_vel();
    p.vby = rand_vel();
    p.ma = rand_mass();
    p.mb = rand_mass();
    if ($urandom_range(0, 99) < 3) begin
      p.ma = '0;
      p.mb = '0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      p.dx = '0;
      p.dy = '0;
    end else if (r < 55) begin
      p.dx = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
      p.dy = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
    end else begin
      p.dx = $urandom();
      p.dy = $urandom();
    end
    if (r >= 5 && r < 10) begin
      if ($urandom_range(0, 1)) p.dx = '0;
      else p.dy = '0;
    end
    return p;
  endfunction

  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Offers one word, logs its expected result and waits for the handshake.
  task automatic send_word(row_t rw);
    int unsigned gap;
    gap = rand_gap();
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    drv = rw.pair;
    in_valid_i = 1'b1;
    pending_q.insert(pending_q.size(), rw.typed ? rw.want : collide(rw.pair));
    do @(negedge clk_i); while (!in_acc);
    words_sent++;
  endtask

  task automatic add_row(pair_t p, bit typed, bounce_t want);
    row_t rw;
    rw.pair = p;
    rw.typed = typed;
    rw.want = want;
    rows_q.insert(rows_q.size(), rw);
  endtask

  // Input handshake seen at the edge, and the no-progress watchdog.
  always @(posedge clk_i) begin
    in_acc <= in_valid_i && !in_stall_o;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result checker: each accepted word against the oldest expectation.
  always @(posedge clk_i) begin
    bounce_t want;
    if (out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        $error("result word with nothing expected");
        fails++;
      end else begin
        want = pending_q.pop_front();
        if (got.ax !== want.ax) begin
          $error("new_a_x: expected %0d, got %0d", want.ax, got.ax);
          fails++;
        end
        if (got.ay !== want.ay) begin
          $error("new_a_y: expected %0d, got %0d", want.ay, got.ay);
          fails++;
        end
        if (got.bx !== want.bx) begin
          $error("new_b_x: expected %0d, got %0d", want.bx, got.bx);
          fails++;
        end
        if (got.by !== want.by) begin
          $error("new_b_y: expected %0d, got %0d", want.by, got.by);
          fails++;
        end
        if (got.degen !== want.degen) begin
          $error("degenerate: expected %0b, got %0b", want.degen, got.degen);
          fails++;
        end
        if (got.sat !== want.sat) begin
          $error("saturated: expected %0b, got %0b", want.sat, got.sat);
          fails++;
        end
        words_back++;
        n_degen += want.degen;
        n_sat += want.sat;
      end
    end
  end

  // Output stall pattern, plus one long hold-off so the pipeline backs up.
  initial begin
    int unsigned seg;
    int unsigned r;
    bit hold_done;
    bit seg_val;
    seg = 0;
    seg_val = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        seg_val = 1'b1;
        seg = 300;
      end else if (seg == 0) begin
        r = $urandom_range(0, 99);
        if (quiet || r < 50) begin
          seg_val = 1'b0;
          seg = $urandom_range(1, 20);
        end else begin
          seg_val = 1'b1;
          if (r < 90) seg = $urandom_range(1, 3);
          else if (r < 98) seg = $urandom_range(4, 12);
          else seg = $urandom_range(30, 80);
        end
      end
      out_stall_i = seg_val;
      seg--;
    end
  end

  // Stimulus: directed table, then random pairs.
  initial begin
    pair_t p;
    bounce_t w;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // All zero: no separation, pass-through of zeros.
    add_row('0, 1'b1, '{0, 0, 0, 0, 1'b1, 1'b0});
    // Zero separation with extreme velocities and masses.
    p = '{SMAX, SMIN, UMAX, SMIN, SMAX, UMAX, 0, 0};
    add_row(p, 1'b1, '{SMAX, SMIN, SMIN, SMAX, 1'b1, 1'b0});
    // Zero mass sum.
    p = '{123456, -7, 0, -99999, 5, 0, 1, 1};
    add_row(p, 1'b1, '{123456, -7, -99999, 5, 1'b1, 1'b0});
    // Equal masses head-on: the velocities swap.
    p = '{ONE, 0, ONE, -ONE, 0, ONE, ONE, 0};
    add_row(p, 1'b1, '{-ONE, 0, ONE, 0, 1'b0, 1'b0});
    // Motion across the separation only: nothing changes.
    p = '{0, ONE, ONE, 0, -ONE, ONE, ONE, 0};
    add_row(p, 1'b1, '{0, ONE, 0, -ONE, 1'b0, 1'b0});
    // One massless body, each side.
    add_row('{ONE, 3 * ONE, 0, -ONE, 2, ONE, ONE, -ONE}, 1'b0, '0);
    add_row('{ONE, 3 * ONE, ONE, -ONE, 2, 0, ONE, -ONE}, 1'b0, '0);
    // Extremes that drive the outputs into saturation.
    add_row('{SMAX, SMAX, UMAX, SMIN, SMIN, UMAX, SMAX, SMIN}, 1'b0, '0);
    add_row('{SMIN, SMAX, 1, SMAX, SMIN, UMAX, SMIN, SMIN}, 1'b0, '0);
    add_row('{SMIN, SMIN, UMAX, SMAX, SMAX, 1, 1, 0}, 1'b0, '0);
    // Minimal masses and separations, rounding ties.
    add_row('{1, -1, 1, -1, 1, 1, 1, 0}, 1'b0, '0);
    add_row('{0, 1, 1, 0, -2, 2, 0, -1}, 1'b0, '0);
    add_row('{3, 0, 1, 0, 0, 2, 1, 1}, 1'b0, '0);
    // Huge separation with small relative speed, and a mass-ratio extreme.
    add_row('{5, 7, ONE, -3, 2, 3 * ONE, SMAX, SMAX}, 1'b0, '0);
    add_row('{ONE, ONE, UMAX, -ONE, -ONE, 1, ONE, ONE}, 1'b0, '0);
    add_row('{-ONE, 2 * ONE, 1, ONE, -ONE, UMAX, -ONE, 7}, 1'b0, '0);

    foreach (rows_q[i]) send_word(rows_q[i]);

    for (int unsigned n = 0; n < RAND_WORDS; n++) begin
      row_t rw;
      if (n == HOLD_AT) hold_req = 1'b1;
      if (n == PAUSE_AT) begin
        in_valid_i = 1'b0;
        while (pending_q.size() != 0) @(negedge clk_i);
      end
      quiet = (n >= QUIET_LO && n < QUIET_HI);
      rw.pair = rand_pair();
      rw.typed = 1'b0;
      rw.want = '0;
      send_word(rw);
    end
    in_valid_i = 1'b0;
    quiet = 1'b0;

    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Covered %0d collision words: %0d degenerate, %0d saturated.",
             words_sent, n_degen, n_sat);
    $display("Directed table plus random pairs under random stalls and one long hold-off.");
    if (fails == 0 && pending_q.size() == 0 && words_back == words_sent) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
